@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PUE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PUE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pue_pkg.sv @@
// shared types, constants and character helpers for the url percent encoder
package pue_pkg;

    localparam int FIFO_DEPTH_DEF = 2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_PLUS,
        KIND_ESC
    } kind_t;

    typedef enum logic [1:0] {
        ST_FIRST,
        ST_HEX_HI,
        ST_HEX_LO
    } step_t;

    typedef struct packed {
        logic [7:0] src;
        kind_t      kind;
        logic       msg_end;
    } item_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hEF));
    endfunction

    function automatic logic is_plain(input logic [7:0] b);
        return ((b >= 8'h40) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A)) ||
               ((b >= 8'h30) && (b <= 8'h39)) ||
               (b == 8'h2A) || (b == 8'h2D) || (b == 8'h2E) || (b == 8'h5F);
    endfunction

endpackage

@@ rtl/pue_front.sv @@
// input side: accepts source bytes, classifies them and tracks the shift-jis trail state
module pue_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_byte,
    input  logic          s_end,
    input  logic          fifo_full,
    output logic          push,
    output pue_pkg::item_t item
);

    logic trail_pending_reg;
    logic trail_pending_next;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        item.src     = s_byte;
        item.msg_end = s_end;
        if (trail_pending_reg || pue_pkg::is_lead(s_byte)) begin
            item.kind = pue_pkg::KIND_ESC;
        end else if (s_byte == pue_pkg::BYTE_SPACE) begin
            item.kind = pue_pkg::KIND_PLUS;
        end else if (pue_pkg::is_plain(s_byte)) begin
            item.kind = pue_pkg::KIND_PLAIN;
        end else begin
            item.kind = pue_pkg::KIND_ESC;
        end
    end

    always_comb begin
        trail_pending_next = trail_pending_reg;
        if (push) begin
            trail_pending_next = !trail_pending_reg && pue_pkg::is_lead(s_byte) && !s_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trail_pending_reg <= 1'b0;
        end else begin
            trail_pending_reg <= trail_pending_next;
        end
    end

endmodule

@@ rtl/pue_fifo.sv @@
// short queue of classified items between the front and back sides
module pue_fifo #(
    parameter int DEPTH = pue_pkg::FIFO_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pue_pkg::item_t push_item,
    input  logic           pop,
    output pue_pkg::item_t head,
    output logic           empty,
    output logic           full
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    pue_pkg::item_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CntW'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/pue_back.sv @@
// output side: expands each queued item into one or three characters, one per cycle while m_ready is high
module pue_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  pue_pkg::item_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_char,
    output logic           m_run_last,
    output logic           m_done
);

    pue_pkg::step_t step_reg, step_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;

    logic       load;
    logic [7:0] cur_char;
    logic       cur_last;

    // output selection for the current step
    always_comb begin
        load = !empty && (!valid_reg || m_ready);
        case (step_reg)
            pue_pkg::ST_FIRST: begin
                case (head.kind)
                    pue_pkg::KIND_PLAIN: begin
                        cur_char = head.src;
                        cur_last = 1'b1;
                    end
                    pue_pkg::KIND_PLUS: begin
                        cur_char = pue_pkg::CH_PLUS;
                        cur_last = 1'b1;
                    end
                    default: begin
                        cur_char = pue_pkg::CH_PERCENT;
                        cur_last = 1'b0;
                    end
                endcase
            end
            pue_pkg::ST_HEX_HI: begin
                cur_char = pue_pkg::hex_char(head.src[7:4]);
                cur_last = 1'b0;
            end
            default: begin
                cur_char = pue_pkg::hex_char(head.src[3:0]);
                cur_last = 1'b1;
            end
        endcase
        pop = load && cur_last;
    end

    // step sequencing
    always_comb begin
        step_next = step_reg;
        if (load) begin
            if (cur_last) begin
                step_next = pue_pkg::ST_FIRST;
            end else begin
                case (step_reg)
                    pue_pkg::ST_FIRST:  step_next = pue_pkg::ST_HEX_HI;
                    pue_pkg::ST_HEX_HI: step_next = pue_pkg::ST_HEX_LO;
                    default:            step_next = pue_pkg::ST_FIRST;
                endcase
            end
        end
    end

    // output register
    always_comb begin
        valid_next = valid_reg && !m_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = cur_char;
            last_next  = cur_last;
            done_next  = cur_last && head.msg_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= pue_pkg::ST_FIRST;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_valid    = valid_reg;
    assign m_char     = char_reg;
    assign m_run_last = last_reg;
    assign m_done     = done_reg;

endmodule

@@ rtl/url_percent_encoder_sjis.sv @@
// top level of the url percent encoder with shift-jis trail handling
// Each input transfer carries one source byte, with tlast marking the final byte of a string.
// A space leaves as '+', '@', letters, digits, '*', '-', '.' and '_' leave unchanged, and any
// other byte, a shift-jis lead byte and the byte right after a lead byte leave as '%' and two
// upper-case hex digits. Output tlast marks the last character of each source byte and tuser the
// last character of the whole string. The output register sends one character per cycle while
// m_axis_tready is high, so a byte yields one character when it passes or becomes '+' and
// three characters when it is escaped; the input side takes a byte every cycle while the
// FIFO_DEPTH-entry queue has room. Each item passes through the queue and the output register.
module url_percent_encoder_sjis #(
    parameter int FIFO_DEPTH = pue_pkg::FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // src_byte
    input  logic       s_axis_tlast,  // msg_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // enc_char
    output logic       m_axis_tlast,  // run_last
    output logic       m_axis_tuser   // string_done
);

    pue_pkg::item_t push_item;
    pue_pkg::item_t head_item;
    logic push;
    logic pop;
    logic fifo_empty;
    logic fifo_full;

    pue_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_byte    (s_axis_tdata),
        .s_end     (s_axis_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .item      (push_item)
    );

    pue_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head_item),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    pue_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head_item),
        .empty      (fifo_empty),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_char     (m_axis_tdata),
        .m_run_last (m_axis_tlast),
        .m_done     (m_axis_tuser)
    );

endmodule

@@ rtl/pue_checker.sv @@
// port-level checker for the url percent encoder, bound to the top level
`include "assert_macros.svh"

module pue_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChPlus    = 8'h2B;

    logic        done_beat;
    logic        pct_beat;
    logic        plus_beat;
    logic        out_stall;
    logic [10:0] out_beat;

    assign done_beat = m_axis_tvalid && m_axis_tuser;
    assign pct_beat  = m_axis_tvalid && (m_axis_tdata == ChPercent);
    assign plus_beat = m_axis_tvalid && (m_axis_tdata == ChPlus);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_beat  = {m_axis_tvalid, m_axis_tdata, m_axis_tlast, m_axis_tuser};

    // string end only on the last character of a byte
    `PUE_ASSERT_IMPL(a_done_is_last, aclk, aresetn, done_beat, m_axis_tlast, "done without last")
    // an escape opener is never the last character of its byte
    `PUE_ASSERT_IMPL(a_percent_not_last, aclk, aresetn, pct_beat, !m_axis_tlast, "percent is last")
    // a plus always stands alone
    `PUE_ASSERT_IMPL(a_plus_is_last, aclk, aresetn, plus_beat, m_axis_tlast, "plus not alone")
    // a stalled transfer holds
    `PUE_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, $stable(out_beat), "stall changed")

endmodule

bind url_percent_encoder_sjis pue_checker u_pue_checker (.*);
